### rtl/mqtt_publish_header_parser_assert.svh
// ---------------------------------------------------------------------------
// MQTT PUBLISH header parser assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef MQTT_PUBLISH_HEADER_PARSER_ASSERT_SVH
`define MQTT_PUBLISH_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define MPH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mph_pkg.sv
// ---------------------------------------------------------------------------
// mph_pkg
// Types and constants shared by the MQTT PUBLISH header parser.
// ---------------------------------------------------------------------------
`default_nettype none

package mph_pkg;

  localparam int unsigned MAX_VARINT_BYTES_DEF = 4;
  localparam int unsigned VCNT_W               = 3;

  localparam logic [7:0] QOS_MASK = 8'h06;

  localparam logic [2:0] CLS_FIXED   = 3'd0;
  localparam logic [2:0] CLS_LEN     = 3'd1;
  localparam logic [2:0] CLS_TLEN    = 3'd2;
  localparam logic [2:0] CLS_TOPIC   = 3'd3;
  localparam logic [2:0] CLS_PID     = 3'd4;
  localparam logic [2:0] CLS_PAYLOAD = 3'd5;

  typedef struct packed {
    logic       packet_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        length_error;
    logic        header_done;
    logic [15:0] packet_id;
    logic [15:0] topic_length;
    logic [27:0] remaining_length;
    logic [1:0]  qos_level;
    logic [7:0]  byte_value;
    logic [2:0]  byte_class;
  } result_t;

endpackage

`default_nettype wire

### rtl/mph_in_reg.sv
// ---------------------------------------------------------------------------
// mph_in_reg
// Input register: holds one received word until the parser takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module mph_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mph_pkg::in_item_t in_item,
  output logic                   item_valid,
  input  wire logic              item_ready,
  output mph_pkg::in_item_t      item
);
  import mph_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (item_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/mph_parse.sv
// ---------------------------------------------------------------------------
// mph_parse
// Parse state, per-byte classification and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mqtt_publish_header_parser_assert.svh"

module mph_parse #(
  parameter int unsigned MAX_VARINT_BYTES = mph_pkg::MAX_VARINT_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire mph_pkg::in_item_t item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output mph_pkg::result_t       res
);
  import mph_pkg::*;

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_LEN     = 3'd1,
    PH_TLEN    = 3'd2,
    PH_TOPIC   = 3'd3,
    PH_PID     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_OVERRUN = 3'd6
  } phase_t;

  localparam logic [VCNT_W-1:0] MAX_CNT = VCNT_W'(MAX_VARINT_BYTES);

  phase_t            phase_r, phase_nxt, cur_phase;
  logic [7:0]        fh_r, fh_nxt, cur_fh;
  logic [27:0]       acc_r, acc_nxt, cur_acc, acc_add;
  logic [VCNT_W-1:0] cnt_r, cnt_nxt, cur_cnt;
  logic [15:0]       tl_r, tl_nxt, cur_tl;
  logic [15:0]       left_r, left_nxt, cur_left;
  logic [15:0]       pid_r, pid_nxt, cur_pid;
  logic              idx_r, idx_nxt, cur_idx;
  logic              res_valid_r;
  result_t           res_r, res_nxt;
  logic              fire, start, qos_nz, done;
  logic [2:0]        cls;
  logic [7:0]        b;

  assign item_ready = !res_valid_r || res_ready;
  assign fire       = item_valid && item_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  assign start = item.packet_start;
  assign b     = item.data_byte;

  always_comb begin
    cur_phase = start ? PH_FIXED : phase_r;
    cur_fh    = start ? 8'h00 : fh_r;
    cur_acc   = start ? 28'h0 : acc_r;
    cur_cnt   = start ? '0 : cnt_r;
    cur_tl    = start ? 16'h0 : tl_r;
    cur_left  = start ? 16'h0 : left_r;
    cur_pid   = start ? 16'h0 : pid_r;
    cur_idx   = start ? 1'b0 : idx_r;
  end

  assign qos_nz = (cur_fh & QOS_MASK) != 8'h00;

  always_comb begin
    unique case (cur_cnt[1:0])
      2'd0: acc_add = {21'h0, b[6:0]};
      2'd1: acc_add = {14'h0, b[6:0], 7'h0};
      2'd2: acc_add = {7'h0, b[6:0], 14'h0};
      2'd3: acc_add = {b[6:0], 21'h0};
    endcase
  end

  always_comb begin
    phase_nxt = cur_phase;
    fh_nxt    = cur_fh;
    acc_nxt   = cur_acc;
    cnt_nxt   = cur_cnt;
    tl_nxt    = cur_tl;
    left_nxt  = cur_left;
    pid_nxt   = cur_pid;
    idx_nxt   = cur_idx;
    done      = 1'b0;
    cls       = CLS_PAYLOAD;
    unique case (cur_phase)
      PH_FIXED: begin
        cls       = CLS_FIXED;
        fh_nxt    = b;
        acc_nxt   = 28'h0;
        cnt_nxt   = '0;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        cls = CLS_LEN;
        if (cur_cnt >= MAX_CNT) begin
          phase_nxt = PH_OVERRUN;
        end else begin
          acc_nxt = cur_acc + acc_add;
          cnt_nxt = cur_cnt + VCNT_W'(1);
          if (!b[7]) begin
            phase_nxt = PH_TLEN;
            idx_nxt   = 1'b0;
          end
        end
      end
      PH_TLEN: begin
        cls = CLS_TLEN;
        if (!cur_idx) begin
          tl_nxt  = {b, 8'h00};
          idx_nxt = 1'b1;
        end else begin
          tl_nxt   = cur_tl | {8'h00, b};
          left_nxt = cur_tl | {8'h00, b};
          idx_nxt  = 1'b0;
          if ((cur_tl | {8'h00, b}) != 16'h0) begin
            phase_nxt = PH_TOPIC;
          end else if (qos_nz) begin
            phase_nxt = PH_PID;
          end else begin
            phase_nxt = PH_PAYLOAD;
            done      = 1'b1;
          end
        end
      end
      PH_TOPIC: begin
        cls      = CLS_TOPIC;
        left_nxt = cur_left - 16'h1;
        if (cur_left == 16'h1) begin
          if (qos_nz) begin
            phase_nxt = PH_PID;
            idx_nxt   = 1'b0;
          end else begin
            phase_nxt = PH_PAYLOAD;
            done      = 1'b1;
          end
        end
      end
      PH_PID: begin
        cls = CLS_PID;
        if (!cur_idx) begin
          pid_nxt = {b, 8'h00};
          idx_nxt = 1'b1;
        end else begin
          pid_nxt   = cur_pid | {8'h00, b};
          idx_nxt   = 1'b0;
          phase_nxt = PH_PAYLOAD;
          done      = 1'b1;
        end
      end
      default: begin
        cls = CLS_PAYLOAD;
      end
    endcase
  end

  always_comb begin
    res_nxt.byte_class       = cls;
    res_nxt.byte_value       = b;
    res_nxt.qos_level        = fh_nxt[2:1];
    res_nxt.remaining_length = acc_nxt;
    res_nxt.topic_length     = (phase_nxt == PH_TLEN) ? 16'h0 : tl_nxt;
    res_nxt.packet_id        = (phase_nxt == PH_PID) ? 16'h0 : pid_nxt;
    res_nxt.header_done      = done;
    res_nxt.length_error     = (phase_nxt == PH_OVERRUN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIXED;
      fh_r        <= 8'h00;
      acc_r       <= 28'h0;
      cnt_r       <= '0;
      tl_r        <= 16'h0;
      left_r      <= 16'h0;
      pid_r       <= 16'h0;
      idx_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      fh_r        <= fh_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      tl_r        <= tl_nxt;
      left_r      <= left_nxt;
      pid_r       <= pid_nxt;
      idx_r       <= idx_nxt;
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  `MPH_ASSERT_NEXT(a_start_is_fixed, fire && start, res_r.byte_class == CLS_FIXED, "start word not classed as fixed header")
  `MPH_ASSERT_NEXT(a_overrun_sticks, fire && !start && phase_r == PH_OVERRUN, res_r.length_error && res_r.byte_class == CLS_PAYLOAD, "overrun not held until next packet")
  `MPH_ASSERT_NOW(a_err_class, res_valid_r && res_r.length_error, res_r.byte_class == CLS_LEN || res_r.byte_class == CLS_PAYLOAD, "length error on wrong class")
  `MPH_ASSERT_NOW(a_done_class, res_valid_r && res_r.header_done, res_r.byte_class == CLS_TLEN || res_r.byte_class == CLS_TOPIC || res_r.byte_class == CLS_PID, "header done on wrong class")
  `MPH_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MAX_CNT, "varint count past limit")

endmodule

`default_nettype wire

### rtl/mqtt_publish_header_parser.sv
// ---------------------------------------------------------------------------
// mqtt_publish_header_parser
// Classifies each byte of an MQTT PUBLISH packet and tracks header fields.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while out_tready does not stall it and returns one
// classified word per byte, in order, on out_tvalid. Each byte passes through
// the input register and then the parse state update into the result
// register; back-pressure on out_tready stalls both stages without losing or
// repeating a word.
`default_nettype none

module mqtt_publish_header_parser #(
  parameter int unsigned MAX_VARINT_BYTES = mph_pkg::MAX_VARINT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] packet_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [7:0] byte_value, [9:8] qos_level,
                                       // [37:10] remaining_length,
                                       // [53:38] topic_length,
                                       // [69:54] packet_id, [70] header_done,
                                       // [71] length_error
  output logic [2:0]       out_tuser   // [2:0] byte_class
);
  import mph_pkg::*;

  in_item_t in_item, item;
  logic     item_valid, item_ready;
  result_t  res;

  assign in_item.data_byte    = in_tdata;
  assign in_item.packet_start = in_tuser;

  mph_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  mph_parse #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tuser = res.byte_class;
  assign out_tdata = {res.length_error, res.header_done, res.packet_id,
                      res.topic_length, res.remaining_length, res.qos_level,
                      res.byte_value};

endmodule

`default_nettype wire
